// ===== design/dbq_pkg.sv =====
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dbq_pkg;

    localparam int DEPTH   = 1024;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 11;
    localparam int COUNT_W = 11;
    localparam int KIND_W  = 3;
    localparam int WORD_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_REAR  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_REAR   = 3'd3,
        KIND_PEEK       = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_LOAD
    } t_cell_op;

    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic             load;
        logic [CNT_W-1:0] load_pos;
    } t_chain_ctrl;

    typedef struct packed {
        logic               ok;
        t_word              front_value;
        t_word              rear_value;
        logic               is_empty;
        logic               is_full;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

// ===== design/bounded_double_ended_queue.sv =====
// A result is registered in the result buffer when its item is transferred.
// Throughput: one item per cycle while o_stall is low; the two cell chains update in the same cycle.
// The input stalls only when both result buffer entries are held.
// Reset clears the count, sets capacity to 1024 and empties the result
// buffer; cell contents are not reset and are only read once written.
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed words held in two chains of cells, one ordered
// from the front and one from the rear, so both ends sit at fixed cells.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [dbq_pkg::CAP_W-1:0]    i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [dbq_pkg::KIND_W-1:0]   i_kind,
    input  wire logic signed [31:0]           i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_ok,
    output logic signed [31:0]                o_front_value,
    output logic signed [31:0]                o_rear_value,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic [dbq_pkg::COUNT_W-1:0]       o_count
);

    logic [dbq_pkg::CAP_W-1:0] r_capacity;
    logic [dbq_pkg::CNT_W-1:0] r_count, n_count;
    logic [dbq_pkg::CNT_W-1:0] w_limit;
    logic                      w_accept, w_full, w_empty, w_ok, w_outq_full;
    dbq_pkg::t_chain_ctrl      w_ctrl_a, w_ctrl_b;
    dbq_pkg::t_word            w_a0, w_a1, w_b0, w_b1, w_front, w_rear;
    dbq_pkg::t_result          w_res, w_out;

    assign o_stall  = w_outq_full;
    assign w_accept = i_valid && !w_outq_full;

    always_comb begin
        if (32'(r_capacity) > 32'(dbq_pkg::DEPTH)) begin
            w_limit = dbq_pkg::CNT_W'(dbq_pkg::DEPTH);
        end else begin
            w_limit = dbq_pkg::CNT_W'(r_capacity);
        end
    end

    assign w_full  = r_count >= w_limit;
    assign w_empty = r_count == '0;

    always_comb begin
        n_count  = r_count;
        w_ok     = 1'b0;
        w_ctrl_a = '0;
        w_ctrl_b = '0;
        w_front  = w_a0;
        w_rear   = w_b0;
        unique case (dbq_pkg::t_kind'(i_kind))
            dbq_pkg::KIND_PUSH_FRONT: begin
                if (!w_full) begin
                    w_ok              = 1'b1;
                    n_count           = r_count + 1'b1;
                    w_ctrl_a.shift_up = 1'b1;
                    w_ctrl_b.load     = 1'b1;
                    w_ctrl_b.load_pos = r_count;
                    w_front           = i_value;
                    w_rear            = w_empty ? i_value : w_b0;
                end
            end
            dbq_pkg::KIND_PUSH_REAR: begin
                if (!w_full) begin
                    w_ok              = 1'b1;
                    n_count           = r_count + 1'b1;
                    w_ctrl_b.shift_up = 1'b1;
                    w_ctrl_a.load     = 1'b1;
                    w_ctrl_a.load_pos = r_count;
                    w_rear            = i_value;
                    w_front           = w_empty ? i_value : w_a0;
                end
            end
            dbq_pkg::KIND_POP_FRONT: begin
                if (!w_empty) begin
                    w_ok                = 1'b1;
                    n_count             = r_count - 1'b1;
                    w_ctrl_a.shift_down = 1'b1;
                    w_front             = w_a1;
                end
            end
            dbq_pkg::KIND_POP_REAR: begin
                if (!w_empty) begin
                    w_ok                = 1'b1;
                    n_count             = r_count - 1'b1;
                    w_ctrl_b.shift_down = 1'b1;
                    w_rear              = w_b1;
                end
            end
            dbq_pkg::KIND_PEEK: begin
                w_ok = 1'b1;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        if (!w_accept) begin
            w_ctrl_a = '0;
            w_ctrl_b = '0;
            n_count  = r_count;
        end
    end

    always_comb begin
        w_res.ok          = w_ok;
        w_res.is_empty    = n_count == '0;
        w_res.front_value = w_res.is_empty ? '0 : w_front;
        w_res.rear_value  = w_res.is_empty ? '0 : w_rear;
        w_res.is_full     = n_count >= w_limit;
        w_res.count       = dbq_pkg::COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= dbq_pkg::CAP_RESET;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_count <= n_count;
        end
    end

    dbq_chain u_chain_front (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl_a),
        .i_value (i_value),
        .o_word0 (w_a0),
        .o_word1 (w_a1)
    );

    dbq_chain u_chain_rear (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl_b),
        .i_value (i_value),
        .o_word0 (w_b0),
        .o_word1 (w_b1)
    );

    dbq_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_res),
        .o_full  (w_outq_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_ok          = w_out.ok;
    assign o_front_value = w_out.front_value;
    assign o_rear_value  = w_out.rear_value;
    assign o_is_empty    = w_out.is_empty;
    assign o_is_full     = w_out.is_full;
    assign o_count       = w_out.count;

endmodule

`default_nettype wire

// ===== design/dbq_cell.sv =====
// ----------------------------------------------------------------------------
// dbq_cell
// One storage cell of the chain: holds a word, or takes it from a neighbour
// or from the write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_cell (
    input  wire logic              i_clk,
    input  wire dbq_pkg::t_cell_op i_op,
    input  wire dbq_pkg::t_word    i_lower,
    input  wire dbq_pkg::t_word    i_upper,
    input  wire dbq_pkg::t_word    i_value,
    output dbq_pkg::t_word         o_word
);

    dbq_pkg::t_word r_word;
    dbq_pkg::t_word n_word;

    always_comb begin
        unique case (i_op)
            dbq_pkg::CELL_SHIFT_UP:   n_word = i_lower;
            dbq_pkg::CELL_SHIFT_DOWN: n_word = i_upper;
            dbq_pkg::CELL_LOAD:       n_word = i_value;
            default:                  n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== design/dbq_chain.sv =====
// ----------------------------------------------------------------------------
// dbq_chain
// Row of cells ordered from one end of the deque. Shifts up to insert at
// cell 0, shifts down to drop cell 0, or loads the cell at a given position.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_chain (
    input  wire logic                 i_clk,
    input  wire dbq_pkg::t_chain_ctrl i_ctrl,
    input  wire dbq_pkg::t_word       i_value,
    output dbq_pkg::t_word            o_word0,
    output dbq_pkg::t_word            o_word1
);

    dbq_pkg::t_word w_word [dbq_pkg::DEPTH];

    for (genvar gi = 0; gi < dbq_pkg::DEPTH; gi++) begin : g_cell
        dbq_pkg::t_cell_op w_op;
        dbq_pkg::t_word    w_lower;
        dbq_pkg::t_word    w_upper;

        if (gi == 0) begin : g_first
            assign w_lower = i_value;
        end else begin : g_mid_lo
            assign w_lower = w_word[gi-1];
        end

        if (gi == dbq_pkg::DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_word[gi+1];
        end

        always_comb begin
            if (i_ctrl.shift_up) begin
                w_op = dbq_pkg::CELL_SHIFT_UP;
            end else if (i_ctrl.shift_down) begin
                w_op = dbq_pkg::CELL_SHIFT_DOWN;
            end else if (i_ctrl.load && (i_ctrl.load_pos == dbq_pkg::CNT_W'(gi))) begin
                w_op = dbq_pkg::CELL_LOAD;
            end else begin
                w_op = dbq_pkg::CELL_HOLD;
            end
        end

        dbq_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .i_value (i_value),
            .o_word  (w_word[gi])
        );
    end

    assign o_word0 = w_word[0];
    assign o_word1 = w_word[1];

endmodule

`default_nettype wire

// ===== design/dbq_outq.sv =====
// ----------------------------------------------------------------------------
// dbq_outq
// Two-entry result buffer between the deque engine and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire dbq_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output dbq_pkg::t_result      o_data
);

    logic             r_v0, r_v1, n_v0, n_v1;
    dbq_pkg::t_result r_d0, r_d1, n_d0, n_d1;
    logic             w_take;

    assign w_take = r_v0 && !i_stall;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (w_take) begin
            n_v0 = r_v1;
            n_d0 = r_d1;
            n_v1 = 1'b0;
        end
        if (i_push) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_d0 = i_data;
            end else begin
                n_v1 = 1'b1;
                n_d1 = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_full  = r_v1;
    assign o_valid = r_v0;
    assign o_data  = r_d0;

endmodule

`default_nettype wire

// ===== design/dbq_checker.sv =====
// ----------------------------------------------------------------------------
// dbq_checker
// Port-level checks on the deque's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic                         o_ok,
    input wire logic signed [31:0]           o_front_value,
    input wire logic signed [31:0]           o_rear_value,
    input wire logic                         o_is_empty,
    input wire logic [dbq_pkg::COUNT_W-1:0]  o_count
);

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_front_value == '0 && o_rear_value == '0))
        else $error("empty deque reports a non-zero word");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_count) <= 32'(dbq_pkg::DEPTH)))
        else $error("count beyond depth");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_count) && $stable(o_ok)))
        else $error("stalled result changed");

endmodule

bind bounded_double_ended_queue dbq_checker u_dbq_checker (.*);

`default_nettype wire

// ===== bench/tb_bounded_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue
// Self-checking bench for the bounded deque. A shadow deque predicts the
// status word of every accepted operation, and each returned status is
// compared field by field in order. Directed corner cases (empty, full,
// capacity lowered below the count, capacity zero, unknown kinds) come
// first. Randomised phases over several capacities, some above depth, follow.
// Both handshakes see random idle gaps.
// ----------------------------------------------------------------------------

import dbq_pkg::*;

class dq_tracker;
    t_word             shadow[$];
    t_result           status_q[$];
    logic [CAP_W-1:0]  capacity = CAP_RESET;
    int                errors = 0;

    task report(string msg);
        $display("MISMATCH: %0s", msg);
        errors++;
    endtask

    function int pending();
        return status_q.size();
    endfunction

    // work out the status after one operation and queue it
    function void apply_op(logic [KIND_W-1:0] kind, t_word value);
        int      lim;
        bit      full;
        t_result st;
        lim  = (capacity > DEPTH) ? DEPTH : int'(capacity);
        full = shadow.size() >= lim;
        st.ok = 1'b0;
        case (kind)
            KIND_PUSH_FRONT: if (!full) begin
                shadow.push_front(value);
                st.ok = 1'b1;
            end
            KIND_PUSH_REAR: if (!full) begin
                shadow.push_back(value);
                st.ok = 1'b1;
            end
            KIND_POP_FRONT: if (shadow.size() != 0) begin
                void'(shadow.pop_front());
                st.ok = 1'b1;
            end
            KIND_POP_REAR: if (shadow.size() != 0) begin
                void'(shadow.pop_back());
                st.ok = 1'b1;
            end
            KIND_PEEK: st.ok = 1'b1;
            default: st.ok = 1'b0;
        endcase
        st.front_value = (shadow.size() != 0) ? shadow[0] : '0;
        st.rear_value  = (shadow.size() != 0) ? shadow[$] : '0;
        st.is_empty    = shadow.size() == 0;
        st.is_full     = shadow.size() >= lim;
        st.count       = COUNT_W'(shadow.size());
        status_q.push_back(st);
    endfunction

    task check_status(t_result got);
        t_result want;
        if (status_q.size() == 0) begin
            report("status returned with none outstanding");
            return;
        end
        want = status_q.pop_front();
        if (got.ok !== want.ok)
            report($sformatf("ok got %0b want %0b", got.ok, want.ok));
        if (got.front_value !== want.front_value)
            report($sformatf("front_value got %0d want %0d",
                             got.front_value, want.front_value));
        if (got.rear_value !== want.rear_value)
            report($sformatf("rear_value got %0d want %0d",
                             got.rear_value, want.rear_value));
        if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty got %0b want %0b", got.is_empty, want.is_empty));
        if (got.is_full !== want.is_full)
            report($sformatf("is_full got %0b want %0b", got.is_full, want.is_full));
        if (got.count !== want.count)
            report($sformatf("count got %0d want %0d", got.count, want.count));
    endtask
endclass

module tb_bounded_double_ended_queue;

    localparam int KIND_LAST  = 2**KIND_W - 1;
    localparam int IDLE_LIMIT = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CAP_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [KIND_W-1:0]  i_kind;
    t_word              i_value;
    logic               o_valid;
    logic               i_stall;
    logic               o_ok;
    t_word              o_front_value;
    t_word              o_rear_value;
    logic               o_is_empty;
    logic               o_is_full;
    logic [COUNT_W-1:0] o_count;

    dq_tracker tracker = new();
    bit        tx_calm;
    bit        rx_calm;
    int        idle_cycles;

    bounded_double_ended_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ok          (o_ok),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_count       (o_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return -1;
            2: return 32'sh7fffffff;
            3: return 32'sh80000000;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
        else if (r < 92)
            return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_REAR;
        else if (r < 97)
            return KIND_PEEK;
        else
            return KIND_W'($urandom_range(int'(KIND_PEEK) + 1, KIND_LAST));
    endfunction

    // one operation: idle gap, present, hold until transfer
    task automatic send_op(input logic [KIND_W-1:0] kind, input t_word value);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = ~tx_calm;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_kind  = kind;
        i_value = value;
        do @(posedge i_clk); while (o_stall);
        tracker.apply_op(kind, value);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        while (tracker.pending() != 0)
            @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = cap;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        tracker.capacity = cap;
    endtask

    task automatic random_phase(input logic [CAP_W-1:0] cap, input int n);
        int push_pct;
        set_capacity(cap);
        push_pct = $urandom_range(25, 75);
        repeat (n)
            send_op(pick_kind(push_pct), pick_word());
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side
    initial begin
        t_result got;
        int      gap;
        i_stall = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = ~rx_calm;
            gap = draw_gap(rx_calm);
            if (gap > 0) begin
                i_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got.ok          = o_ok;
            got.front_value = o_front_value;
            got.rear_value  = o_rear_value;
            got.is_empty    = o_is_empty;
            got.is_full     = o_is_full;
            got.count       = o_count;
            tracker.check_status(got);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [CAP_W-1:0] caps[$];
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_kind      = KIND_PEEK;
        i_value     = '0;
        idle_cycles = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty deque, both word extremes, unknown kinds, reuse after emptying
        send_op(KIND_PEEK, '0);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_PUSH_FRONT, 32'sh7fffffff);
        send_op(KIND_PUSH_REAR, 32'sh80000000);
        send_op(KIND_PUSH_FRONT, -1);
        send_op(KIND_PUSH_REAR, '0);
        send_op(KIND_PEEK, 32'sh12345678);
        for (int k = int'(KIND_PEEK) + 1; k <= KIND_LAST; k++)
            send_op(KIND_W'(k), 32'sh0badf00d);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_PUSH_REAR, 32'sh5a5a5a5a);
        send_op(KIND_PUSH_FRONT, 32'sha5a5a5a5);
        send_op(KIND_PUSH_REAR, 32'sh00000001);

        // capacity lowered below the count
        set_capacity(CAP_W'(1));
        send_op(KIND_PUSH_FRONT, 32'sh11111111);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_PUSH_REAR, 32'sh22222222);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_PUSH_REAR, 32'sh33333333);

        // capacity zero: empty and full at once
        set_capacity(CAP_W'(0));
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_PUSH_FRONT, 32'sh44444444);
        send_op(KIND_PUSH_REAR, 32'sh55555555);

        caps = '{CAP_W'(1), CAP_W'(2), CAP_W'(3), CAP_W'(5), CAP_W'(8), CAP_W'(16),
                 CAP_W'(0), CAP_W'(1025), CAP_W'(1024), CAP_W'(2047),
                 CAP_W'($urandom_range(1, 40)), CAP_W'($urandom_range(0, 2047))};
        foreach (caps[i])
            random_phase(caps[i], 70);

        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dbq_pkg.sv
design/dbq_cell.sv
design/dbq_chain.sv
design/dbq_outq.sv
design/bounded_double_ended_queue.sv
design/dbq_checker.sv
bench/tb_bounded_double_ended_queue.sv
